@@ sv/gcdxr_pkg.sv @@
package gcdxr_pkg;

    // fixed field widths
    localparam int CFG_W    = 11;
    localparam int IN_VAL_W = 32;
    localparam int RANGE_W  = 10;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd2;

endpackage

@@ sv/gcd_excluding_range_query.sv @@
// load: runs the element through the shared binary gcd unit (one step a cycle) to form its prefix
// last load of a set adds the suffix pass over all n elements, from the top down
// query: an error or a whole-array exclusion goes straight to the output; otherwise the gcd unit combines them
// one request at a time; the next request is taken while a result waits at the output
// reset (synchronous, active low) clears control state and count = 1; stores are not cleared
module gcd_excluding_range_query #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [gcdxr_pkg::CFG_W-1:0]         i_cfg_wdata,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [gcdxr_pkg::IN_VAL_W-1:0]      i_element_value,
    input  logic [gcdxr_pkg::RANGE_W-1:0]       i_range_left,
    input  logic [gcdxr_pkg::RANGE_W-1:0]       i_range_right,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [gcdxr_pkg::OUT_W-1:0]         o_gcd_result,
    output logic [gcdxr_pkg::STATUS_W-1:0]      o_status
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CW    = (CNT_W > gcdxr_pkg::CFG_W) ? CNT_W : gcdxr_pkg::CFG_W;
    localparam int K_W   = $clog2(VALUE_BITS) + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_GCD  = 7'b0000010,
        S_SRD  = 7'b0000100,
        S_SGO  = 7'b0001000,
        S_QRD  = 7'b0010000,
        S_QGO  = 7'b0100000,
        S_PUT  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        CTX_LOAD = 2'd0,
        CTX_SUF  = 2'd1,
        CTX_QRY  = 2'd2
    } t_ctx;

    // storage
    logic [VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] pre_mem  [MAX_ELEMENTS];
    logic [VALUE_BITS-1:0] suf_mem  [MAX_ELEMENTS];

    // control and data registers
    t_state                    r_state,   n_state;
    t_ctx                      r_ctx,     n_ctx;
    logic [CNT_W-1:0]          r_count,   n_count;
    logic [CNT_W-1:0]          r_pos,     n_pos;
    logic                      r_ready,   n_ready;
    logic [IDX_W-1:0]          r_idx,     n_idx;
    logic [VALUE_BITS-1:0]     r_prefix,  n_prefix;
    logic [VALUE_BITS-1:0]     r_suffix,  n_suffix;
    logic [VALUE_BITS-1:0]     r_ga,      n_ga;
    logic [VALUE_BITS-1:0]     r_gb,      n_gb;
    logic [K_W-1:0]            r_gk,      n_gk;
    logic [IDX_W-1:0]          r_pre_addr, n_pre_addr;
    logic [IDX_W-1:0]          r_suf_addr, n_suf_addr;
    logic                      r_use_pre, n_use_pre;
    logic                      r_use_suf, n_use_suf;
    logic [VALUE_BITS-1:0]     r_res,     n_res;
    logic [gcdxr_pkg::STATUS_W-1:0] r_rst, n_rst;
    logic                      r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0]     r_out_res, n_out_res;
    logic [gcdxr_pkg::STATUS_W-1:0] r_out_st, n_out_st;

    // memory read data
    logic [VALUE_BITS-1:0]     r_elem_rd;
    logic [VALUE_BITS-1:0]     r_pre_rd;
    logic [VALUE_BITS-1:0]     r_suf_rd;

    logic                      w_in_acc;
    logic [VALUE_BITS-1:0]     w_in_val;
    logic [CNT_W-1:0]          w_load_pos;
    logic [CNT_W-1:0]          w_cfg_count;
    logic [CW-1:0]             w_l;
    logic [CW-1:0]             w_r;
    logic [CW-1:0]             w_n;
    logic                      w_gcd_done;
    logic [VALUE_BITS-1:0]     w_gcd_val;
    logic                      w_elem_we;
    logic                      w_pre_we;
    logic                      w_suf_we;

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_in_acc     = i_in_valid && o_in_ready;
    assign w_in_val     = VALUE_BITS'(i_element_value);
    assign w_load_pos   = (r_ready || (r_pos >= r_count)) ? '0 : r_pos;
    assign w_l          = CW'(i_range_left);
    assign w_r          = CW'(i_range_right);
    assign w_n          = CW'(r_count);

    // clamp the written count to 1..MAX_ELEMENTS
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_count = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_ELEMENTS)) begin
            w_cfg_count = CNT_W'(MAX_ELEMENTS);
        end else begin
            w_cfg_count = CNT_W'(i_cfg_wdata);
        end
    end

    // binary gcd: done once an operand is zero, result is the other times 2^k
    assign w_gcd_done = (r_ga == '0) || (r_gb == '0);
    assign w_gcd_val  = VALUE_BITS'((r_ga | r_gb) << r_gk);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_ctx       = r_ctx;
        n_count     = r_count;
        n_pos       = r_pos;
        n_ready     = r_ready;
        n_idx       = r_idx;
        n_prefix    = r_prefix;
        n_suffix    = r_suffix;
        n_ga        = r_ga;
        n_gb        = r_gb;
        n_gk        = r_gk;
        n_pre_addr  = r_pre_addr;
        n_suf_addr  = r_suf_addr;
        n_use_pre   = r_use_pre;
        n_use_suf   = r_use_suf;
        n_res       = r_res;
        n_rst       = r_rst;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        n_out_st    = r_out_st;
        w_elem_we   = 1'b0;
        w_pre_we    = 1'b0;
        w_suf_we    = 1'b0;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_operation == gcdxr_pkg::OP_LOAD) begin
                        // store element, prefix = gcd(previous prefix, value)
                        w_elem_we = 1'b1;
                        n_pos     = w_load_pos;
                        n_ready   = 1'b0;
                        n_ga      = (w_load_pos == '0) ? '0 : r_prefix;
                        n_gb      = w_in_val;
                        n_gk      = '0;
                        n_ctx     = CTX_LOAD;
                        n_state   = S_GCD;
                    end else begin
                        n_res      = '0;
                        n_rst      = gcdxr_pkg::STATUS_OK;
                        n_use_pre  = (w_l != '0);
                        n_use_suf  = (w_r != w_n - CW'(1));
                        n_pre_addr = IDX_W'(w_l - CW'(1));
                        n_suf_addr = IDX_W'(w_r + CW'(1));
                        priority if (!r_ready) begin
                            n_rst   = gcdxr_pkg::STATUS_NOT_LOADED;
                            n_state = S_PUT;
                        end else if ((w_l > w_r) || (w_r >= w_n)) begin
                            n_rst   = gcdxr_pkg::STATUS_BAD_RANGE;
                            n_state = S_PUT;
                        end else if ((w_l == '0) && (w_r == w_n - CW'(1))) begin
                            // whole array excluded
                            n_state = S_PUT;
                        end else begin
                            n_state = S_QRD;
                        end
                    end
                end
            end
            S_GCD: begin
                if (w_gcd_done) begin
                    unique case (r_ctx)
                        CTX_LOAD: begin
                            w_pre_we = 1'b1;
                            n_prefix = w_gcd_val;
                            n_pos    = CNT_W'(r_pos + CNT_W'(1));
                            if (CNT_W'(r_pos + CNT_W'(1)) == r_count) begin
                                // last element: run the suffix pass from the top
                                n_idx    = IDX_W'(r_count - CNT_W'(1));
                                n_suffix = '0;
                                n_state  = S_SRD;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end
                        CTX_SUF: begin
                            w_suf_we = 1'b1;
                            n_suffix = w_gcd_val;
                            if (r_idx == '0) begin
                                n_ready = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_idx   = r_idx - IDX_W'(1);
                                n_state = S_SRD;
                            end
                        end
                        CTX_QRY: begin
                            n_res   = w_gcd_val;
                            n_rst   = gcdxr_pkg::STATUS_OK;
                            n_state = S_PUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end else begin
                    // one binary gcd step
                    priority if (!r_ga[0] && !r_gb[0]) begin
                        n_ga = r_ga >> 1;
                        n_gb = r_gb >> 1;
                        n_gk = r_gk + K_W'(1);
                    end else if (!r_ga[0]) begin
                        n_ga = r_ga >> 1;
                    end else if (!r_gb[0]) begin
                        n_gb = r_gb >> 1;
                    end else if (r_ga >= r_gb) begin
                        n_ga = (r_ga - r_gb) >> 1;
                    end else begin
                        n_gb = (r_gb - r_ga) >> 1;
                    end
                end
            end
            S_SRD: begin
                // element read in flight
                n_state = S_SGO;
            end
            S_SGO: begin
                n_ga    = r_suffix;
                n_gb    = r_elem_rd;
                n_gk    = '0;
                n_ctx   = CTX_SUF;
                n_state = S_GCD;
            end
            S_QRD: begin
                // prefix and suffix reads in flight
                n_state = S_QGO;
            end
            S_QGO: begin
                n_ga    = r_use_pre ? r_pre_rd : '0;
                n_gb    = r_use_suf ? r_suf_rd : '0;
                n_gk    = '0;
                n_ctx   = CTX_QRY;
                n_state = S_GCD;
            end
            S_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_res   = r_res;
                    n_out_st    = r_rst;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // count write starts a new data set
        if (i_cfg_we) begin
            n_count = w_cfg_count;
            n_pos   = '0;
            n_ready = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ctx       <= CTX_LOAD;
            r_count     <= CNT_W'(1);
            r_pos       <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctx       <= n_ctx;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_prefix   <= n_prefix;
        r_suffix   <= n_suffix;
        r_ga       <= n_ga;
        r_gb       <= n_gb;
        r_gk       <= n_gk;
        r_pre_addr <= n_pre_addr;
        r_suf_addr <= n_suf_addr;
        r_use_pre  <= n_use_pre;
        r_use_suf  <= n_use_suf;
        r_res      <= n_res;
        r_rst      <= n_rst;
        r_out_res  <= n_out_res;
        r_out_st   <= n_out_st;
    end

    // element store
    always_ff @(posedge i_clk) begin
        if (w_elem_we) begin
            elem_mem[w_load_pos[IDX_W-1:0]] <= w_in_val;
        end
        r_elem_rd <= elem_mem[r_idx];
    end

    // prefix gcd store
    always_ff @(posedge i_clk) begin
        if (w_pre_we) begin
            pre_mem[r_pos[IDX_W-1:0]] <= w_gcd_val;
        end
        r_pre_rd <= pre_mem[r_pre_addr];
    end

    // suffix gcd store
    always_ff @(posedge i_clk) begin
        if (w_suf_we) begin
            suf_mem[r_idx] <= w_gcd_val;
        end
        r_suf_rd <= suf_mem[r_suf_addr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_gcd_result = gcdxr_pkg::OUT_W'(r_out_res);
    assign o_status     = r_out_st;

endmodule

@@ sv/gcdxr_checker.sv @@
module gcdxr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [gcdxr_pkg::OUT_W-1:0]    i_gcd_result,
    input  logic [gcdxr_pkg::STATUS_W-1:0] i_status
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_gcd_result)
            && $stable(i_status))
        else $error("result changed while stalled");

    // an error status always carries a zero gcd
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != gcdxr_pkg::STATUS_OK) |-> i_gcd_result == '0)
        else $error("error result with nonzero gcd");

    // one request at a time: ready drops after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while busy");

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("not idle after reset");

endmodule

bind gcd_excluding_range_query gcdxr_checker u_gcdxr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_gcd_result (o_gcd_result),
    .i_status     (o_status)
);
